// ===== rtl/core/mvf_pkg.sv =====
// Shared types and constants for the version flood cell update block.
`timescale 1ns / 1ps

package mvf_pkg;

   localparam int VER_W      = 31;
   localparam int DATA_W     = 8;
   localparam int DIM_W      = 7;
   localparam int COORD_W    = 6;
   localparam int OUT_RANK_W = 8;

   localparam logic OP_UPDATE     = 1'b0;
   localparam logic OP_SET_SOURCE = 1'b1;

   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   typedef struct packed {
      logic start;
      logic self_load;
      logic nb_load;
   } pick_ctrl_type;

endpackage

// ===== rtl/core/mesh_version_flood_cell_update.sv =====
// Top level of the version flood cell update block: sequencer, registers, memory.
//
// The req_ channel carries one beat per item: an update of one cell from its
// neighbors, or a set-source beat that rewrites root cell (0,0). Every item
// gives exactly one rsp_ beat holding the changed flag and the cell afterwards.
// The csr_ channel writes grid_width (index 0) and grid_height (index 1); it is
// always ready and is meant to be written while no item is in flight.
// An update reads the cell and then each of the four neighbor slots through
// the single read port, takes in the last read data, then writes the cell back
// if it changed. Set-source items and cells outside the grid skip the reads.
// One item is in flight at a time; req_ready is high only while the sequencer
// is idle, so no new item is taken until the last has loaded its response.
// The response sits in an output register, so the next item is accepted while
// a response waits; a later item holds before write back until rsp_ready.
// After reset the memory is cleared one cell per cycle, all MAX_WIDTH*MAX_HEIGHT
// cells (4096 at the defaults), with req_ready low; cell 0 comes out pinned
// with rank ROOT_RANK. Configuration writes are taken during the clear.
`timescale 1ns / 1ps

module mesh_version_flood_cell_update import mvf_pkg::*; #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int ROOT_RANK  = 255
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_operation,
   input  logic [COORD_W-1:0]    req_cell_x,
   input  logic [COORD_W-1:0]    req_cell_y,
   input  logic [VER_W-1:0]      req_source_version,
   input  logic [DATA_W-1:0]     req_source_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_changed,
   output logic [VER_W-1:0]      rsp_cell_version,
   output logic [DATA_W-1:0]     rsp_cell_data,
   output logic [OUT_RANK_W-1:0] rsp_cell_rank,
   output logic                  rsp_cell_conflict,
   output logic                  rsp_cell_pinned,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [DIM_W-1:0]      csr_wdata
);

   localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int RANK_W = $clog2(ROOT_RANK + 1);
   localparam int WORD_W = VER_W + DATA_W + RANK_W + 2;

   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(MAX_WIDTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
   localparam logic [RANK_W-1:0] ROOT_R    = RANK_W'(ROOT_RANK);
   localparam logic [WORD_W-1:0] ROOT_WORD = {{(VER_W + DATA_W){1'b0}}, ROOT_R, 1'b1, 1'b0};

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_READ   = 2'd2;
   localparam logic [1:0] S_DECIDE = 2'd3;

   localparam logic [2:0] RD_LAST = 3'd5;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
      logic [DIM_W-1:0] d;
      d = v;
      if (d == '0) d = DIM_W'(1);
      if (int'(d) > maxv) d = DIM_W'(maxv);
      return d;
   endfunction

   localparam logic [DIM_W-1:0] W_RESET = (MAX_WIDTH < 64) ? DIM_W'(MAX_WIDTH) : DIM_W'(64);
   localparam logic [DIM_W-1:0] H_RESET = (MAX_HEIGHT < 64) ? DIM_W'(MAX_HEIGHT) : DIM_W'(64);

   logic [1:0]           state_ff, state_in;
   logic [ADDR_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [2:0]           rd_cnt_ff, rd_cnt_in;
   logic                 set_ff, set_in;
   logic                 oob_ff, oob_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;
   logic [3:0]           nbv_ff, nbv_in;
   logic [VER_W-1:0]     src_ver_ff;
   logic [DATA_W-1:0]    src_data_ff;
   logic [DIM_W-1:0]     width_ff, height_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_changed_ff;
   logic [VER_W-1:0]      rsp_ver_ff;
   logic [DATA_W-1:0]     rsp_data_ff;
   logic [OUT_RANK_W-1:0] rsp_rank_ff;
   logic                  rsp_conf_ff;
   logic                  rsp_pin_ff;

   logic                  req_fire;
   logic                  load_rsp;
   logic [DIM_W-1:0]      x_ext, y_ext;
   logic                  in_grid;
   logic [1:0]            nb_sel;

   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [WORD_W-1:0]     mem_wr_data;
   logic                  mem_rd_en;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [WORD_W-1:0]     mem_rd_data;

   pick_ctrl_type         pick_ctrl;
   logic [VER_W-1:0]      self_ver, next_ver;
   logic [DATA_W-1:0]     self_data, next_data;
   logic [RANK_W-1:0]     self_rank, next_rank;
   logic                  self_pinned, self_conflict, next_conflict, pick_changed;

   logic                  out_changed;
   logic [VER_W-1:0]      out_ver;
   logic [DATA_W-1:0]     out_data;
   logic [RANK_W-1:0]     out_rank;
   logic                  out_conf;
   logic                  out_pin;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign load_rsp  = (state_ff == S_DECIDE) && (!rsp_valid_ff || rsp_ready);

   assign x_ext   = DIM_W'(req_cell_x);
   assign y_ext   = DIM_W'(req_cell_y);
   assign in_grid = (x_ext < width_ff) && (y_ext < height_ff);
   assign nb_sel  = 2'(rd_cnt_ff - 3'd2);

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      rd_cnt_in  = rd_cnt_ff;
      set_in     = set_ff;
      oob_in     = oob_ff;
      idx_in     = idx_ff;
      nbv_in     = nbv_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               set_in    = (req_operation == OP_SET_SOURCE);
               oob_in    = !in_grid;
               idx_in    = ADDR_W'(req_cell_y) * ROW_STEP + ADDR_W'(req_cell_x);
               nbv_in[0] = (req_cell_y != '0);
               nbv_in[1] = (x_ext + DIM_W'(1)) < width_ff;
               nbv_in[2] = (y_ext + DIM_W'(1)) < height_ff;
               nbv_in[3] = (req_cell_x != '0);
               rd_cnt_in = '0;
               if (req_operation == OP_SET_SOURCE || !in_grid) begin
                  state_in = S_DECIDE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            rd_cnt_in = rd_cnt_ff + 3'd1;
            if (rd_cnt_ff == RD_LAST) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
         rd_cnt_ff  <= '0;
         set_ff     <= 1'b0;
         oob_ff     <= 1'b0;
         width_ff   <= W_RESET;
         height_ff  <= H_RESET;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         rd_cnt_ff  <= rd_cnt_in;
         set_ff     <= set_in;
         oob_ff     <= oob_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_GRID_WIDTH:  width_ff  <= clamp_dim(csr_wdata, MAX_WIDTH);
               CSR_GRID_HEIGHT: height_ff <= clamp_dim(csr_wdata, MAX_HEIGHT);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      nbv_ff <= nbv_in;
      if (req_fire) begin
         src_ver_ff  <= req_source_version;
         src_data_ff <= req_source_data;
      end
   end

   always_comb begin
      mem_rd_en = (state_ff == S_READ) && (rd_cnt_ff < RD_LAST);
      unique case (rd_cnt_ff)
         3'd1:    mem_rd_addr = idx_ff - ROW_STEP;
         3'd2:    mem_rd_addr = idx_ff + ADDR_W'(1);
         3'd3:    mem_rd_addr = idx_ff + ROW_STEP;
         3'd4:    mem_rd_addr = idx_ff - ADDR_W'(1);
         default: mem_rd_addr = idx_ff;
      endcase
   end

   always_comb begin
      pick_ctrl.start     = req_fire;
      pick_ctrl.self_load = (state_ff == S_READ) && (rd_cnt_ff == 3'd1);
      pick_ctrl.nb_load   = (state_ff == S_READ) && (rd_cnt_ff >= 3'd2) && nbv_ff[nb_sel];
   end

   mvf_cell_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W),
      .WORD_W (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   mvf_pick #(
      .ROOT_RANK (ROOT_RANK)
   ) u_pick (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (pick_ctrl),
      .rd_ver        (mem_rd_data[WORD_W-1 -: VER_W]),
      .rd_data       (mem_rd_data[RANK_W+2 +: DATA_W]),
      .rd_rank       (mem_rd_data[2 +: RANK_W]),
      .rd_pinned     (mem_rd_data[1]),
      .rd_conflict   (mem_rd_data[0]),
      .self_ver      (self_ver),
      .self_data     (self_data),
      .self_rank     (self_rank),
      .self_pinned   (self_pinned),
      .self_conflict (self_conflict),
      .next_ver      (next_ver),
      .next_data     (next_data),
      .next_rank     (next_rank),
      .next_conflict (next_conflict),
      .changed       (pick_changed)
   );

   always_comb begin
      priority if (set_ff) begin
         out_changed = 1'b1;
         out_ver     = src_ver_ff;
         out_data    = src_data_ff;
         out_rank    = ROOT_R;
         out_conf    = 1'b0;
         out_pin     = 1'b1;
      end else if (oob_ff) begin
         out_changed = 1'b0;
         out_ver     = '0;
         out_data    = '0;
         out_rank    = '0;
         out_conf    = 1'b0;
         out_pin     = 1'b0;
      end else if (pick_changed) begin
         out_changed = 1'b1;
         out_ver     = next_ver;
         out_data    = next_data;
         out_rank    = next_rank;
         out_conf    = next_conflict;
         out_pin     = 1'b0;
      end else begin
         out_changed = 1'b0;
         out_ver     = self_ver;
         out_data    = self_data;
         out_rank    = self_rank;
         out_conf    = self_conflict;
         out_pin     = self_pinned;
      end
   end

   always_comb begin
      if (state_ff == S_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_cnt_ff;
         mem_wr_data = (clr_cnt_ff == '0) ? ROOT_WORD : '0;
      end else begin
         mem_wr_en   = load_rsp && out_changed;
         mem_wr_addr = set_ff ? '0 : idx_ff;
         mem_wr_data = {out_ver, out_data, out_rank, out_pin, out_conf};
      end
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_changed_ff <= out_changed;
         rsp_ver_ff     <= out_ver;
         rsp_data_ff    <= out_data;
         rsp_rank_ff    <= OUT_RANK_W'(out_rank);
         rsp_conf_ff    <= out_conf;
         rsp_pin_ff     <= out_pin;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_changed       = rsp_changed_ff;
   assign rsp_cell_version  = rsp_ver_ff;
   assign rsp_cell_data     = rsp_data_ff;
   assign rsp_cell_rank     = rsp_rank_ff;
   assign rsp_cell_conflict = rsp_conf_ff;
   assign rsp_cell_pinned   = rsp_pin_ff;

   a_write_only_clear_or_decide: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == S_CLEAR) || (state_ff == S_DECIDE))
      else $error("Cell memory written outside clear or write back.");

   a_unpinned_write_below_root: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && (state_ff == S_DECIDE) && !out_pin) |-> (out_rank < ROOT_R))
      else $error("Unpinned cell written with root rank or above.");

   a_conflict_has_no_rank: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && out_conf) |-> (out_rank == '0))
      else $error("Cell in conflict reported with a nonzero rank.");

   a_no_accept_during_item: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("Second item accepted while one is in flight.");

endmodule

// ===== rtl/core/mvf_cell_ram.sv =====
// Single-port-write, single-port-read cell memory with registered read data.
`timescale 1ns / 1ps

module mvf_cell_ram #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12,
   parameter int WORD_W = 49
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mvf_pick.sv =====
// Candidate selection over the neighbor read stream and next cell computation.
`timescale 1ns / 1ps

module mvf_pick import mvf_pkg::*; #(
   parameter int ROOT_RANK = 255
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pick_ctrl_type                   ctrl,
   input  logic [VER_W-1:0]                rd_ver,
   input  logic [DATA_W-1:0]               rd_data,
   input  logic [$clog2(ROOT_RANK+1)-1:0]  rd_rank,
   input  logic                            rd_pinned,
   input  logic                            rd_conflict,
   output logic [VER_W-1:0]                self_ver,
   output logic [DATA_W-1:0]               self_data,
   output logic [$clog2(ROOT_RANK+1)-1:0]  self_rank,
   output logic                            self_pinned,
   output logic                            self_conflict,
   output logic [VER_W-1:0]                next_ver,
   output logic [DATA_W-1:0]               next_data,
   output logic [$clog2(ROOT_RANK+1)-1:0]  next_rank,
   output logic                            next_conflict,
   output logic                            changed
);

   localparam int RANK_W = $clog2(ROOT_RANK + 1);
   localparam logic [RANK_W-1:0] TOP_RANK = RANK_W'(ROOT_RANK - 1);

   logic [VER_W-1:0]  self_ver_ff;
   logic [DATA_W-1:0] self_data_ff;
   logic [RANK_W-1:0] self_rank_ff;
   logic              self_pin_ff;
   logic              self_conf_ff;
   logic              found_ff;
   logic              tie_ff;
   logic [VER_W-1:0]  sv_ff;
   logic [DATA_W-1:0] sd_ff;
   logic [RANK_W-1:0] sr_ff;

   logic usable;
   logic relevant;
   logic better;
   logic same;
   logic [RANK_W-1:0] rank_raw;

   always_comb begin
      usable   = (rd_rank != '0) && !rd_conflict;
      relevant = (self_rank_ff == '0) || (rd_ver > self_ver_ff) ||
                 ((rd_ver == self_ver_ff) && (rd_rank > self_rank_ff));
      better   = (rd_ver > sv_ff) || ((rd_ver == sv_ff) && (rd_rank > sr_ff));
      same     = (rd_ver == sv_ff) && (rd_rank == sr_ff) && (rd_data != sd_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         tie_ff   <= 1'b0;
      end else if (ctrl.start) begin
         found_ff <= 1'b0;
         tie_ff   <= 1'b0;
      end else if (ctrl.nb_load && usable && relevant) begin
         if (better) begin
            found_ff <= 1'b1;
            tie_ff   <= 1'b0;
         end else if (same) begin
            tie_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         sv_ff <= '0;
         sd_ff <= '0;
         sr_ff <= '0;
      end else if (ctrl.nb_load && usable && relevant && better) begin
         sv_ff <= rd_ver;
         sd_ff <= rd_data;
         sr_ff <= rd_rank;
      end
      if (ctrl.self_load) begin
         self_ver_ff  <= rd_ver;
         self_data_ff <= rd_data;
         self_rank_ff <= rd_rank;
         self_pin_ff  <= rd_pinned;
         self_conf_ff <= rd_conflict;
      end
   end

   always_comb begin
      if (!found_ff) begin
         next_ver      = self_ver_ff;
         next_data     = self_data_ff;
         rank_raw      = '0;
         next_conflict = self_conf_ff;
      end else if (tie_ff) begin
         next_ver      = (sv_ff > self_ver_ff) ? sv_ff : self_ver_ff;
         next_data     = self_data_ff;
         rank_raw      = '0;
         next_conflict = 1'b1;
      end else begin
         next_ver      = sv_ff;
         next_data     = sd_ff;
         rank_raw      = (sr_ff != '0) ? sr_ff - RANK_W'(1) : '0;
         next_conflict = 1'b0;
      end
      next_rank = (rank_raw > TOP_RANK) ? TOP_RANK : rank_raw;
      changed   = !self_pin_ff &&
                  ((next_ver != self_ver_ff) || (next_data != self_data_ff) ||
                   (next_rank != self_rank_ff) || (next_conflict != self_conf_ff));
   end

   assign self_ver      = self_ver_ff;
   assign self_data     = self_data_ff;
   assign self_rank     = self_rank_ff;
   assign self_pinned   = self_pin_ff;
   assign self_conflict = self_conf_ff;

endmodule
